// File: design/sto_pkg.sv
package sto_pkg;

    localparam int MaxRank  = 4;
    localparam int SizeW    = 16;
    localparam int StepW    = 32;
    localparam int IdxW     = 48;
    localparam int PosW     = 50;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int QuoW     = 48;

    typedef enum logic [0:0] {
        OP_LINEAR = 1'b0,
        OP_COORD  = 1'b1
    } op_t;

    typedef struct packed {
        logic             op;
        logic [IdxW-1:0]  linear_index;
        logic [SizeW-1:0] coord0;
        logic [SizeW-1:0] coord1;
        logic [SizeW-1:0] coord2;
        logic [SizeW-1:0] coord3;
    } in_word_t;

    typedef struct packed {
        logic [PosW-1:0] storage_pos;
        logic            error;
    } out_word_t;

    typedef struct packed {
        logic             op;
        logic             bad;
        logic [QuoW-1:0]  rem;
        logic [QuoW-1:0]  quo;
        logic [SizeW-1:0] coord;
        logic [PosW-1:0]  pos;
    } lane_t;

endpackage

// File: design/sto_div_cell.sv
// One radix-2 restoring division step: the partial remainder shifts in one dividend bit, the quotient one bit.
module sto_div_cell (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [sto_pkg::SizeW-1:0] divisor,
    input  logic [sto_pkg::QuoW-1:0] rem_in,
    input  logic [sto_pkg::QuoW-1:0] quo_in,
    input  logic [sto_pkg::SizeW:0]  part_in,
    output logic [sto_pkg::QuoW-1:0] rem_out,
    output logic [sto_pkg::QuoW-1:0] quo_out,
    output logic [sto_pkg::SizeW:0]  part_out
);
    logic [sto_pkg::SizeW+1:0] trial;
    logic [sto_pkg::SizeW:0]   part_next;
    logic [sto_pkg::QuoW-1:0]  quo_next;

    // shift next dividend bit, subtract if it fits
    always_comb begin
        trial = {part_in, rem_in[sto_pkg::QuoW-1]};
        quo_next = {quo_in[sto_pkg::QuoW-2:0], 1'b0};
        if (trial >= {2'b00, divisor}) begin
            part_next = (sto_pkg::SizeW+1)'(trial - {2'b00, divisor});
            quo_next[0] = 1'b1;
        end else begin
            part_next = trial[sto_pkg::SizeW:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= {rem_in[sto_pkg::QuoW-2:0], 1'b0};
            quo_out  <= quo_next;
            part_out <= part_next;
        end
    end
endmodule

// File: design/sto_dim_cell.sv
// Per-dimension cell: for a linear index, divide by size over a chain of bit cells; for a coordinate,
// check it against size; then multiply the coordinate by the stride and accumulate.
module sto_dim_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      vld_in,
    input  logic [sto_pkg::SizeW-1:0] size,
    input  logic [sto_pkg::StepW-1:0] step,
    input  sto_pkg::lane_t            lane_in,
    output logic                      vld_out,
    output sto_pkg::lane_t            lane_out
);
    localparam int N = sto_pkg::QuoW;
    localparam int L = N + 2;

    logic [sto_pkg::QuoW-1:0] rem_c  [N+1];
    logic [sto_pkg::QuoW-1:0] quo_c  [N+1];
    logic [sto_pkg::SizeW:0]  part_c [N+1];
    sto_pkg::lane_t           side_reg [N];
    logic [L-1:0]             vld_reg;
    logic [sto_pkg::SizeW-1:0] c_reg;
    logic [sto_pkg::SizeW-1:0] c_next;
    logic [sto_pkg::QuoW-1:0]  q_reg;
    logic [sto_pkg::QuoW-1:0]  q_next;
    sto_pkg::lane_t            m_reg;
    sto_pkg::lane_t            m_next;
    logic [sto_pkg::SizeW+sto_pkg::StepW-1:0] prod_reg;
    sto_pkg::lane_t            a_reg;
    sto_pkg::lane_t            a_next;
    logic                      use_div;

    assign use_div = (lane_in.op == sto_pkg::OP_LINEAR);
    assign rem_c[0]  = use_div ? lane_in.quo : '0;
    assign quo_c[0]  = '0;
    assign part_c[0] = '0;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_bit
            sto_div_cell u_cell (
                .aclk(aclk), .en(en), .divisor(size),
                .rem_in(rem_c[i]), .quo_in(quo_c[i]), .part_in(part_c[i]),
                .rem_out(rem_c[i+1]), .quo_out(quo_c[i+1]), .part_out(part_c[i+1])
            );
        end
    endgenerate

    // carry the side data alongside the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= lane_in;
            for (int k = 1; k < N; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    // pick coordinate and check range
    always_comb begin
        m_next = side_reg[N-1];
        if (side_reg[N-1].op == sto_pkg::OP_LINEAR) begin
            c_next = part_c[N][sto_pkg::SizeW-1:0];
            q_next = quo_c[N];
        end else begin
            c_next = side_reg[N-1].coord;
            q_next = side_reg[N-1].quo;
            if (side_reg[N-1].coord >= size) m_next.bad = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= m_next;
            c_reg <= c_next;
            q_reg <= q_next;
        end
    end

    // multiply, then accumulate
    always_comb begin
        a_next = m_reg;
        a_next.quo = q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= c_reg * step;
            a_reg <= a_next;
        end
    end

    always_comb begin
        lane_out = a_reg;
        lane_out.pos = a_reg.pos + sto_pkg::PosW'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[L-2:0], vld_in};
    end
    assign vld_out = vld_reg[L-1];
endmodule

// File: design/strided_tensor_offset_core.sv
// Throughput: one word per cycle while the output register is not stalled; each dimension
// cell is a 48-stage restoring divider chain plus range check and 16x32 multiply stages.
// The whole pipeline stalls while the output register is full and not taken.
// Reset (aresetn, synchronous, low): sizes to 1, strides to 0, pipeline empty.
module strided_tensor_offset_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sto_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sto_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sto_pkg::in_word_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sto_pkg::out_word_t           m_data
);
    localparam int R = sto_pkg::MaxRank;
    localparam int CL = sto_pkg::QuoW + 2;

    logic [sto_pkg::SizeW-1:0] size_reg [R];
    logic [sto_pkg::StepW-1:0] step_reg [R];
    logic                      size_zero;
    logic                      en;
    logic                      in_vld_reg;
    sto_pkg::lane_t            in_lane_reg;
    sto_pkg::lane_t            in_lane_next;
    logic [sto_pkg::SizeW-1:0] cd_reg [3][3*CL+1];
    logic                      vld_c [R+1];
    sto_pkg::lane_t            lane_c [R+1];
    logic                      res_bad;
    logic                      out_vld_reg;
    sto_pkg::out_word_t        out_reg;
    sto_pkg::out_word_t        out_next;

    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < R; d++) begin
                size_reg[d] <= sto_pkg::SizeW'(1);
                step_reg[d] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index < sto_pkg::CfgIdxW'(R))
                size_reg[cfg_index[1:0]] <= cfg_data[sto_pkg::SizeW-1:0];
            else
                step_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // flag an empty dimension: no linear index is then in range
    always_comb begin
        size_zero = 1'b0;
        for (int d = 0; d < R; d++)
            if (size_reg[d] == '0) size_zero = 1'b1;
    end

    assign en = !out_vld_reg || m_ready;
    assign s_ready = en;

    // register the input word
    always_comb begin
        in_lane_next.op    = s_data.op;
        in_lane_next.bad   = 1'b0;
        in_lane_next.rem   = '0;
        in_lane_next.quo   = s_data.linear_index;
        in_lane_next.coord = s_data.coord3;
        in_lane_next.pos   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) in_vld_reg <= 1'b0;
        else if (en) in_vld_reg <= s_valid;
        if (en) in_lane_reg <= in_lane_next;
    end

    // coordinate fields differ per cell; delay by the cell latency
    always_ff @(posedge aclk) begin
        if (en) begin
            cd_reg[0][0] <= s_data.coord2;
            cd_reg[1][0] <= s_data.coord1;
            cd_reg[2][0] <= s_data.coord0;
            for (int j = 0; j < 3; j++)
                for (int k = 1; k < 3*CL+1; k++) cd_reg[j][k] <= cd_reg[j][k-1];
        end
    end

    assign vld_c[0]  = in_vld_reg;
    assign lane_c[0] = in_lane_reg;

    // innermost dimension first
    generate
        for (genvar c = 0; c < R; c++) begin : g_dim
            sto_pkg::lane_t li;
            if (c == 0) begin : g_head
                assign li = lane_c[c];
            end else begin : g_tail
                always_comb begin
                    li = lane_c[c];
                    li.coord = cd_reg[c-1][c*CL];
                end
            end
            sto_dim_cell u_dim (
                .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(vld_c[c]),
                .size(size_reg[R-1-c]), .step(step_reg[R-1-c]),
                .lane_in(li), .vld_out(vld_c[c+1]), .lane_out(lane_c[c+1])
            );
        end
    endgenerate

    // a linear index is in range only if nothing is left after every division
    assign res_bad = lane_c[R].bad ||
                     ((lane_c[R].op == sto_pkg::OP_LINEAR) &&
                      (size_zero || (lane_c[R].quo != '0)));

    always_comb begin
        out_next.error       = res_bad;
        out_next.storage_pos = res_bad ? '0 : lane_c[R].pos;
    end

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= vld_c[R];
        if (en) out_reg <= out_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;
endmodule

// File: tb/sto_offset_checker.sv
`timescale 1ns / 100ps

module sto_offset_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sto_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sto_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  sto_pkg::in_word_t            s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  sto_pkg::out_word_t           m_data,
    output int                           fail_count,
    output int                           pending_count
);
    logic [sto_pkg::SizeW-1:0] shape [sto_pkg::MaxRank];
    logic [sto_pkg::StepW-1:0] stride [sto_pkg::MaxRank];
    sto_pkg::out_word_t        offset_queue [$];

    // Saturating element count; zero if any dimension is empty
    function automatic logic [63:0] element_total();
        logic [127:0] n;
        n = 1;
        for (int d = 0; d < sto_pkg::MaxRank; d++) begin
            if (shape[d] == 0) return 64'd0;
            n = n * shape[d];
            if (n > 128'hFFFF_FFFF_FFFF_FFFF) n = 128'hFFFF_FFFF_FFFF_FFFF;
        end
        return n[63:0];
    endfunction

    function automatic sto_pkg::out_word_t predict_word(sto_pkg::in_word_t w);
        sto_pkg::out_word_t r;
        logic [63:0] idx;
        logic [63:0] pos;
        logic [15:0] c [sto_pkg::MaxRank];
        logic bad;
        pos = 0;
        bad = 1'b0;
        if (w.op == sto_pkg::OP_LINEAR) begin
            idx = 64'(w.linear_index);
            if (idx >= element_total()) begin
                bad = 1'b1;
            end else begin
                for (int d = sto_pkg::MaxRank - 1; d >= 0; d--) begin
                    pos = pos + (idx % shape[d]) * stride[d];
                    idx = idx / shape[d];
                end
            end
        end else begin
            c[0] = w.coord0; c[1] = w.coord1; c[2] = w.coord2; c[3] = w.coord3;
            for (int d = 0; d < sto_pkg::MaxRank; d++) begin
                if (c[d] >= shape[d]) bad = 1'b1;
                else if (!bad) pos = pos + c[d] * stride[d];
            end
        end
        r.storage_pos = bad ? '0 : pos[sto_pkg::PosW-1:0];
        r.error       = bad;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        sto_pkg::out_word_t want;
        if (!aresetn) begin
            for (int d = 0; d < sto_pkg::MaxRank; d++) begin
                shape[d]  <= 1;
                stride[d] <= 0;
            end
            offset_queue.delete();
            fail_count = 0;
            pending_count = 0;
        end else begin
            // Predict on accept, using the settings in force now
            if (s_valid && s_ready) offset_queue.push_back(predict_word(s_data));
            if (m_valid && m_ready) begin
                if (offset_queue.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = offset_queue.pop_front();
                    if (m_data.storage_pos !== want.storage_pos)
                        report_mismatch($sformatf("storage_pos %0h expected %0h",
                            m_data.storage_pos, want.storage_pos));
                    if (m_data.error !== want.error)
                        report_mismatch($sformatf("error %0b expected %0b",
                            m_data.error, want.error));
                end
            end
            pending_count = offset_queue.size();
            if (cfg_we) begin
                if (cfg_index < sto_pkg::MaxRank)
                    shape[cfg_index[1:0]] <= cfg_data[sto_pkg::SizeW-1:0];
                else
                    stride[cfg_index[1:0]] <= cfg_data;
            end
        end
    end
endmodule

// File: tb/tb_strided_tensor_offset_core.sv
`timescale 1ns / 100ps

module tb_strided_tensor_offset_core;
    localparam int Latency = 201;
    localparam int CycleLimit = 1000000;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [sto_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [sto_pkg::CfgDataW-1:0] cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    sto_pkg::in_word_t            s_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    sto_pkg::out_word_t           m_data;
    int                           fail_count;
    int                           pending_count;
    int                           cycle_count = 0;
    logic [sto_pkg::SizeW-1:0]    shape [sto_pkg::MaxRank];

    strided_tensor_offset_core uut (.*);

    sto_offset_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Guard against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Randomly stall the result side, with quiet stretches
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if ((cycle_count / 2000) % 3 == 2) m_ready <= 1'b1;
            else begin
                hold = gap_len();
                m_ready <= (hold == 0);
                repeat (hold) @(posedge aclk);
                if (hold != 0) m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(int idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sto_pkg::CfgIdxW'(idx);
        cfg_data  <= val;
        if (idx < sto_pkg::MaxRank) shape[idx] = val[sto_pkg::SizeW-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (Latency + 20) @(posedge aclk);
    endtask

    // Drop valid only across an idle gap, so back-to-back words keep it high
    task automatic send_word(sto_pkg::in_word_t w, bit idle);
        int hold;
        hold = idle ? gap_len() : 0;
        if (hold != 0) begin
            s_valid <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord(logic [15:0] lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim == 0 || r == 0) return 16'($urandom);
        if (r == 1) return lim;
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic sto_pkg::in_word_t rand_word();
        sto_pkg::in_word_t w;
        logic [63:0] total;
        w.op = $urandom_range(0, 1) ? sto_pkg::OP_COORD : sto_pkg::OP_LINEAR;
        w.coord0 = pick_coord(shape[0]);
        w.coord1 = pick_coord(shape[1]);
        w.coord2 = pick_coord(shape[2]);
        w.coord3 = pick_coord(shape[3]);
        total = 64'(shape[0]) * shape[1] * shape[2] * shape[3];
        w.linear_index = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 8 && total != 0)
            w.linear_index = 48'({$urandom, $urandom} % total);
        else if ($urandom_range(0, 1) && total != 0)
            w.linear_index = 48'(total - 1 + $urandom_range(0, 1));
        return w;
    endfunction

    initial begin
        sto_pkg::in_word_t w;
        logic [15:0] s;
        for (int d = 0; d < sto_pkg::MaxRank; d++) shape[d] = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, then extremes
        w = '0;
        send_word(w, 0);
        w = '1;
        send_word(w, 0);
        w.op = sto_pkg::OP_COORD;
        w.linear_index = '0;
        w.coord0 = 0; w.coord1 = 0; w.coord2 = 0; w.coord3 = 0;
        send_word(w, 0);
        drain();
        // Full shape, full strides: widest offset
        for (int d = 0; d < sto_pkg::MaxRank; d++) write_reg(d, 32'hFFFF);
        for (int d = 0; d < sto_pkg::MaxRank; d++)
            write_reg(sto_pkg::MaxRank + d, 32'hFFFF_FFFF);
        w.op = sto_pkg::OP_COORD;
        w.coord0 = 16'hFFFE; w.coord1 = 16'hFFFE; w.coord2 = 16'hFFFE; w.coord3 = 16'hFFFE;
        send_word(w, 0);
        w.coord3 = 16'hFFFF;
        send_word(w, 0);
        w.op = sto_pkg::OP_LINEAR;
        w.linear_index = 48'hFFFF_FFFF_FFFF;
        send_word(w, 0);
        w.linear_index = 48'hFFFC_0005_FFFC;
        send_word(w, 0);
        drain();
        // Zero size in one dimension
        write_reg(2, 0);
        w.linear_index = 0;
        send_word(w, 0);
        w.op = sto_pkg::OP_COORD;
        w.coord0 = 0; w.coord1 = 0; w.coord2 = 0; w.coord3 = 0;
        send_word(w, 0);
        drain();

        // Random phases over varied shapes
        for (int ph = 0; ph < 17; ph++) begin
            for (int d = 0; d < sto_pkg::MaxRank; d++) begin
                case ($urandom_range(0, 5))
                    0: s = 1;
                    1: s = (ph == 3) ? 0 : 1;
                    2: s = 16'hFFFF;
                    3: s = 16'($urandom);
                    default: s = 16'($urandom_range(1, 12));
                endcase
                write_reg(d, {16'($urandom_range(0, 65535)), s});
                write_reg(sto_pkg::MaxRank + d,
                          (ph == 5) ? 32'hFFFF_FFFF : (ph == 6) ? 0 : $urandom);
            end
            for (int i = 0; i < 50; i++) send_word(rand_word(), ph % 4 != 1);
            drain();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
